// ===== sv/owbm_pkg.sv =====
`timescale 1ns / 1ps

package owbm_pkg;

    localparam int CFG_COUNT = 8;
    localparam int CFG_W     = 12;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_RESET_IDLE  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRES_WAIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_W1_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_W1_HIGH     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_W0_LOW      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_W0_HIGH     = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_READ_LOW    = 3'd7;

    localparam logic [CFG_W-1:0] CFG_RESET_VAL [CFG_COUNT] = '{
        12'd1000, 12'd1000, 12'd60, 12'd2, 12'd62, 12'd65, 12'd5, 12'd5
    };

    localparam logic [1:0] OP_NONE  = 2'd0;
    localparam logic [1:0] OP_RESET = 2'd1;
    localparam logic [1:0] OP_WRITE = 2'd2;
    localparam logic [1:0] OP_READ  = 2'd3;

    localparam logic [7:0] CRC_POLY = 8'h8C;

    typedef enum logic [3:0] {
        PH_IDLE      = 4'd0,
        PH_RST_IDLE1 = 4'd1,
        PH_RST_LOW   = 4'd2,
        PH_RST_WAIT  = 4'd3,
        PH_RST_IDLE2 = 4'd4,
        PH_W_LOW     = 4'd5,
        PH_W_HIGH    = 4'd6,
        PH_R_LOW     = 4'd7,
        PH_R_WAIT    = 4'd8,
        PH_R_TAIL    = 4'd9
    } t_phase;

    typedef struct packed {
        logic [1:0] operation;
        logic [7:0] write_data;
        logic       crc_restart;
        logic       line_level;
    } t_bus_in;

    typedef struct packed {
        logic       drive_low;
        logic       busy_res;
        logic       done_res;
        logic       presence_detected;
        logic [7:0] rx_byte;
        logic [7:0] crc_value;
        logic       command_ignored;
    } t_bus_out;

endpackage

// ===== sv/one_wire_bus_master.sv =====
`timescale 1ns / 1ps
// Each accepted word has its result word registered at the edge that accepts it.
// Throughput: one word per cycle; the output register decouples the two sides,
// so a new word is taken whenever the result register is empty or being read.
// Timing of bus phases is counted in accepted words (ticks), not clock cycles.
// Reset (i_rst_n low, synchronous): phase idle, counters/CRC/read byte cleared,
// configuration registers loaded with their default slot timings.
module one_wire_bus_master
    import owbm_pkg::*;
#(
    parameter int READ_SAMPLE_TICKS = 5,
    parameter int READ_TAIL_TICKS   = 70,
    parameter int COUNTER_BITS      = 12
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [CFG_W-1:0]     i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  t_bus_in              i_in_word,
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output t_bus_out             o_out_word
);

    localparam int CW = COUNTER_BITS;

    logic [CFG_W-1:0] r_cfg [CFG_COUNT];

    t_phase         r_phase, n_phase, w_phase_s;
    logic [CW-1:0]  r_tick, n_tick;
    logic [2:0]     r_bit, n_bit;
    logic [7:0]     r_shift, n_shift;
    logic [7:0]     r_crc, n_crc;
    logic           r_pres, n_pres;
    logic [1:0]     r_cmd, n_cmd;
    logic [7:0]     r_last, n_last;

    logic           r_out_valid;
    t_bus_out       r_out_word;

    logic           w_in_acc;
    logic           w_done, w_ign, w_busy, w_drive;
    logic [CW-1:0]  w_raw, w_lim;
    logic [CW:0]    w_inc;
    logic           w_mix;

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = !r_out_valid || i_out_ready;
    assign w_in_acc    = i_in_valid && o_in_ready;
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < CFG_COUNT; k++) begin
                r_cfg[k] <= CFG_RESET_VAL[k];
            end
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_cfg[i_cfg_index] <= i_cfg_data;
        end
    end

    // phase seen by this word, after a possible command start
    always_comb begin
        w_phase_s = r_phase;
        if (r_phase == PH_IDLE) begin
            unique case (i_in_word.operation)
                OP_RESET: w_phase_s = PH_RST_IDLE1;
                OP_WRITE: w_phase_s = PH_W_LOW;
                OP_READ:  w_phase_s = PH_R_LOW;
                default:  w_phase_s = PH_IDLE;
            endcase
        end
    end

    always_comb begin
        n_phase = w_phase_s;
        n_tick  = r_tick;
        n_bit   = r_bit;
        n_shift = r_shift;
        n_crc   = r_crc;
        n_pres  = r_pres;
        n_cmd   = r_cmd;
        n_last  = r_last;
        w_done  = 1'b0;
        w_ign   = 1'b0;
        w_raw   = '0;
        w_lim   = '0;
        w_inc   = '0;
        w_mix   = 1'b0;

        if (r_phase != PH_IDLE) begin
            w_ign = (i_in_word.operation != OP_NONE);
        end else if (i_in_word.operation != OP_NONE) begin
            n_cmd  = i_in_word.operation;
            n_tick = '0;
            n_bit  = '0;
            if (i_in_word.operation == OP_WRITE) begin
                n_shift = i_in_word.write_data;
            end else if (i_in_word.operation == OP_READ) begin
                n_shift = '0;
                if (i_in_word.crc_restart) begin
                    n_crc = '0;
                end
            end
        end

        unique case (w_phase_s)
            PH_RST_IDLE1, PH_RST_IDLE2: w_raw = CW'(r_cfg[CFG_RESET_IDLE]);
            PH_RST_LOW:  w_raw = CW'(r_cfg[CFG_RESET_LOW]);
            PH_RST_WAIT: w_raw = CW'(r_cfg[CFG_PRES_WAIT]);
            PH_W_LOW:    w_raw = n_shift[0] ? CW'(r_cfg[CFG_W1_LOW])
                                            : CW'(r_cfg[CFG_W0_LOW]);
            PH_W_HIGH:   w_raw = n_shift[0] ? CW'(r_cfg[CFG_W1_HIGH])
                                            : CW'(r_cfg[CFG_W0_HIGH]);
            PH_R_LOW:    w_raw = CW'(r_cfg[CFG_READ_LOW]);
            PH_R_WAIT:   w_raw = CW'(READ_SAMPLE_TICKS);
            default:     w_raw = CW'(READ_TAIL_TICKS);
        endcase
        w_lim = (w_raw == '0) ? CW'(1) : w_raw;
        w_inc = {1'b0, n_tick} + (CW+1)'(1);

        if (w_phase_s != PH_IDLE) begin
            if (w_inc >= {1'b0, w_lim}) begin
                n_tick = '0;
                unique case (w_phase_s)
                    PH_RST_IDLE1: n_phase = PH_RST_LOW;
                    PH_RST_LOW:   n_phase = PH_RST_WAIT;
                    PH_RST_WAIT: begin
                        n_pres  = !i_in_word.line_level;
                        n_phase = PH_RST_IDLE2;
                    end
                    PH_RST_IDLE2: begin
                        n_phase = PH_IDLE;
                        w_done  = 1'b1;
                    end
                    PH_W_LOW:     n_phase = PH_W_HIGH;
                    PH_W_HIGH: begin
                        n_shift = {1'b0, n_shift[7:1]};
                        if (n_bit == 3'd7) begin
                            n_phase = PH_IDLE;
                            w_done  = 1'b1;
                        end else begin
                            n_bit   = n_bit + 3'd1;
                            n_phase = PH_W_LOW;
                        end
                    end
                    PH_R_LOW:     n_phase = PH_R_WAIT;
                    PH_R_WAIT: begin
                        n_shift = {i_in_word.line_level, n_shift[7:1]};
                        w_mix   = n_crc[0] ^ i_in_word.line_level;
                        n_crc   = {1'b0, n_crc[7:1]} ^ (w_mix ? CRC_POLY : 8'h00);
                        n_phase = PH_R_TAIL;
                    end
                    PH_R_TAIL: begin
                        if (n_bit == 3'd7) begin
                            n_last  = n_shift;
                            n_phase = PH_IDLE;
                            w_done  = 1'b1;
                        end else begin
                            n_bit   = n_bit + 3'd1;
                            n_phase = PH_R_LOW;
                        end
                    end
                    default: n_phase = PH_IDLE;
                endcase
            end else begin
                n_tick = w_inc[CW-1:0];
            end
        end
    end

    always_comb begin
        w_busy  = (w_phase_s != PH_IDLE);
        w_drive = (w_phase_s == PH_RST_LOW) || (w_phase_s == PH_W_LOW)
               || (w_phase_s == PH_R_LOW);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_tick      <= '0;
            r_bit       <= '0;
            r_shift     <= '0;
            r_crc       <= '0;
            r_pres      <= 1'b0;
            r_cmd       <= OP_NONE;
            r_last      <= '0;
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_phase     <= n_phase;
            r_tick      <= n_tick;
            r_bit       <= n_bit;
            r_shift     <= n_shift;
            r_crc       <= n_crc;
            r_pres      <= n_pres;
            r_cmd       <= n_cmd;
            r_last      <= n_last;
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_out_word.drive_low         <= w_drive;
            r_out_word.busy_res          <= w_busy;
            r_out_word.done_res          <= w_done;
            r_out_word.presence_detected <= n_pres;
            r_out_word.rx_byte           <= n_last;
            r_out_word.crc_value         <= n_crc;
            r_out_word.command_ignored   <= w_ign;
        end
    end

    a_done_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.done_res) |-> r_out_word.busy_res)
        else $error("done without busy");

    a_drive_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_word.drive_low) |-> r_out_word.busy_res)
        else $error("bus driven while not busy");

    a_ignored: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> (r_out_valid && (r_out_word.command_ignored ==
            ($past(r_phase != PH_IDLE) && $past(i_in_word.operation != OP_NONE)))))
        else $error("ignored flag mismatch");

    a_cmd_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase != PH_IDLE) |-> (r_cmd != OP_NONE))
        else $error("sequence running without a command");

    a_bit_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_IDLE && r_cmd != OP_NONE) |-> (r_tick == '0))
        else $error("tick count not cleared at sequence end");

endmodule
